// ----- sv/arpc_pkg.sv -----
// arpc_pkg: shared types and constants of the arp cache and responder
`timescale 1ns / 1ps
`default_nettype none

package arpc_pkg;

  // cache geometry
  localparam int unsigned CACHE_ENTRIES = 4;
  localparam int unsigned CacheIdxW     = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

  // arp header constants, wire order
  localparam logic [15:0] MinArpLen  = 16'd28;
  localparam logic [15:0] HwEthernet = 16'h0001;
  localparam logic [15:0] ProtoIpv4  = 16'h0800;
  localparam logic [15:0] OpRequest  = 16'd1;
  localparam logic [15:0] OpResponse = 16'd2;

  // configuration port
  localparam int unsigned CfgDataW = 48;

  typedef enum logic {
    REG_OWN_MAC = 1'b0,
    REG_OWN_IP  = 1'b1
  } reg_idx_e;

  typedef enum logic {
    FUNC_RESOLVE = 1'b0,
    FUNC_RX_MSG  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    TX_NONE    = 2'd0,
    TX_REQUEST = 2'd1,
    TX_REPLY   = 2'd2
  } tx_kind_e;

  // input beat
  typedef struct packed {
    logic        func;
    logic [31:0] query_ip;
    logic [15:0] frame_len;
    logic [15:0] hw_type;
    logic [15:0] proto_code;
    logic [15:0] op_code;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
  } arpc_req_t;

  // result beat
  typedef struct packed {
    logic        hit;
    logic [47:0] resolved_mac;
    tx_kind_e    tx_kind;
    logic [47:0] tx_target_mac;
    logic [31:0] tx_target_ip;
    logic        cache_written;
  } arpc_res_t;

  // cache insert request
  typedef struct packed {
    logic        en;
    logic [31:0] ip;
    logic [47:0] mac;
  } arpc_wr_t;

  // cache lookup answer
  typedef struct packed {
    logic        hit;
    logic [47:0] mac;
  } arpc_hit_t;

endpackage

`default_nettype wire

// ----- sv/arpc_cache.sv -----
// arpc_cache: ip to mac cache with parallel lookup and round-robin insert
`timescale 1ns / 1ps
`default_nettype none

module arpc_cache import arpc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [31:0] lookup_ip_i,
  output arpc_hit_t        lookup_o,
  input  wire arpc_wr_t    wr_i
);

  logic [31:0]          entry_ip_q  [CACHE_ENTRIES];
  logic [47:0]          entry_mac_q [CACHE_ENTRIES];
  logic [CacheIdxW-1:0] ptr_q, ptr_d;

  // first match in index order wins: scan from the top so lower entries override
  always_comb begin
    lookup_o = '0;
    for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
      if (entry_ip_q[i] == lookup_ip_i) begin
        lookup_o.hit = 1'b1;
        lookup_o.mac = entry_mac_q[i];
      end
    end
  end

  // round-robin insert pointer
  always_comb begin
    ptr_d = ptr_q;
    if (wr_i.en) begin
      if (ptr_q == CacheIdxW'(CACHE_ENTRIES - 1)) begin
        ptr_d = '0;
      end else begin
        ptr_d = ptr_q + CacheIdxW'(1);
      end
    end
  end

  // entries reset to zero, so ip zero hits with mac zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        entry_ip_q[i]  <= '0;
        entry_mac_q[i] <= '0;
      end
    end else begin
      ptr_q <= ptr_d;
      if (wr_i.en) begin
        entry_ip_q[ptr_q]  <= wr_i.ip;
        entry_mac_q[ptr_q] <= wr_i.mac;
      end
    end
  end

`ifndef ASSERT_OFF
  // an insert lands at the slot the pointer named
  a_insert_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i.en |=> (entry_ip_q[$past(ptr_q)] == $past(wr_i.ip)) &&
                (entry_mac_q[$past(ptr_q)] == $past(wr_i.mac)))
    else $error("cache insert did not land at the insert pointer");

  // the pointer only moves on an insert
  a_ptr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !wr_i.en |=> $stable(ptr_q))
    else $error("insert pointer moved without an insert");

  // an insert never duplicates an ip that is already cached
  a_no_dup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i.en && (wr_i.ip == lookup_ip_i) |-> !lookup_o.hit)
    else $error("insert of an ip that is already cached");
`endif

endmodule

`default_nettype wire

// ----- sv/arp_cache_and_responder.sv -----
// arp_cache_and_responder: arp offload engine with a small ip to mac cache
//
//   channel   ports                                 handshake
//   -------   -----------------------------------   ---------------------------------
//   input     start, busy, req_i                    beat taken when start && !busy
//   result    res_valid_o, res_o                    beat shown for one cycle, no stall
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i      write taken when cfg_we_i
//
// one beat is taken every cycle; busy is always low
// a result passes through the input register, then a single
//   compare against all cache entries in parallel and the result register
// back-to-back beats see each other's cache inserts in order
// reset clears the cache, the insert pointer, own ip and the pipeline valids
// the receiver cannot stall, so nothing is ever held back
`timescale 1ns / 1ps
`default_nettype none

module arp_cache_and_responder import arpc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output      logic                busy,
  input  wire arpc_req_t           req_i,
  output      logic                res_valid_o,
  output      arpc_res_t           res_o,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  // own mac is needed only by the frame builder; writes to it are dropped here
  logic [31:0] own_ip_q;

  arpc_req_t in_q;
  logic      in_valid_q;
  arpc_res_t res_q, res_d;
  logic      res_valid_q;

  logic      msg_ok;
  arpc_hit_t look;
  arpc_wr_t  wr;

  assign busy = 1'b0;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_OWN_MAC: ;
        REG_OWN_IP:  own_ip_q <= cfg_wdata_i[31:0];
        default:     ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      in_q <= req_i;
    end
  end

  // cache lookup on the query ip or the sender ip
  arpc_cache u_cache (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lookup_ip_i ((in_q.func == FUNC_RX_MSG) ? in_q.sender_ip : in_q.query_ip),
    .lookup_o    (look),
    .wr_i        (wr)
  );

  // message acceptance checks
  assign msg_ok = (in_q.frame_len >= MinArpLen) && (in_q.hw_type == HwEthernet) &&
                  (in_q.proto_code == ProtoIpv4) && (in_q.target_ip == own_ip_q);

  // insert on a valid response from an ip not yet cached
  always_comb begin
    wr.en  = in_valid_q && (in_q.func == FUNC_RX_MSG) && msg_ok &&
             (in_q.op_code == OpResponse) && !look.hit;
    wr.ip  = in_q.sender_ip;
    wr.mac = in_q.sender_mac;
  end

  // result beat
  always_comb begin
    res_d = '0;
    res_d.tx_kind = TX_NONE;
    if (in_q.func == FUNC_RESOLVE) begin
      if (look.hit) begin
        res_d.hit          = 1'b1;
        res_d.resolved_mac = look.mac;
      end else begin
        res_d.tx_kind      = TX_REQUEST;
        res_d.tx_target_ip = in_q.query_ip;
      end
    end else if (msg_ok && (in_q.op_code == OpRequest)) begin
      res_d.tx_kind       = TX_REPLY;
      res_d.tx_target_mac = in_q.sender_mac;
      res_d.tx_target_ip  = in_q.sender_ip;
    end else begin
      res_d.cache_written = wr.en;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef ASSERT_OFF
  // every beat held in the input register gives exactly one result in the next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q |=> res_valid_q)
    else $error("accepted beat produced no result");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |=> !res_valid_q)
    else $error("result without an accepted beat");

  // a hit sends nothing and writes nothing
  a_hit_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.hit |-> (res_q.tx_kind == TX_NONE) && !res_q.cache_written)
    else $error("hit result with a send or a cache write");

  // nothing to send means no target fields
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && (res_q.tx_kind == TX_NONE) |->
      (res_q.tx_target_ip == '0) && (res_q.tx_target_mac == '0))
    else $error("target fields set with nothing to send");
`endif

endmodule

`default_nettype wire
